// File: sv/rpbri_pkg.sv
// ----------------------------------------------------------------------------
// rpbri_pkg
// Shared types and constants for the radix page bucket range index block.
// ----------------------------------------------------------------------------
package rpbri_pkg;

   localparam logic [15:0] FANOUT_RESET = 16'd512;
   localparam logic [63:0] ALL_ONES     = {64{1'b1}};
   localparam int unsigned DIV_STEPS    = 64;

   // datapath operations issued by the controller
   typedef enum logic [3:0] {
      OP_NONE,
      OP_LOAD,
      OP_POW,
      OP_SPAN,
      OP_RANGE,
      OP_OFF,
      OP_CLO,
      OP_CHI,
      OP_SDIV_INIT,
      OP_DIV,
      OP_SSAVE,
      OP_ASAVE,
      OP_PUB
   } op_type;

   typedef struct packed {
      op_type op;
   } cmd_type;

   typedef struct packed {
      logic pow_done;
      logic div_done;
      logic out_free;
   } status_type;

   typedef struct packed {
      logic [7:0]  page_level;
      logic [63:0] page_first_bucket;
      logic [63:0] query_bucket;
      logic [31:0] query_child;
   } req_type;

   typedef struct packed {
      logic [63:0] range_low;
      logic [63:0] range_high;
      logic [15:0] slot_for_bucket;
      logic        bucket_absent;
      logic [63:0] child_low;
      logic [63:0] child_high;
      logic        child_bad;
      logic [63:0] aligned_bucket;
   } rsp_type;

endpackage

// File: sv/rpbri_ifs.sv
// ----------------------------------------------------------------------------
// rpbri request and response channels
// Valid/ready channels carrying one page query and one result.
// ----------------------------------------------------------------------------
interface rpbri_req_if;
   logic        valid;
   logic        ready;
   logic [7:0]  page_level;
   logic [63:0] page_first_bucket;
   logic [63:0] query_bucket;
   logic [31:0] query_child;
   modport source(output valid, page_level, page_first_bucket, query_bucket, query_child,
                  input ready);
   modport sink(input valid, page_level, page_first_bucket, query_bucket, query_child,
                output ready);
endinterface

interface rpbri_rsp_if;
   logic        valid;
   logic        ready;
   logic [63:0] range_low;
   logic [63:0] range_high;
   logic [15:0] slot_for_bucket;
   logic        bucket_absent;
   logic [63:0] child_low;
   logic [63:0] child_high;
   logic        child_bad;
   logic [63:0] aligned_bucket;
   modport source(output valid, range_low, range_high, slot_for_bucket, bucket_absent,
                  child_low, child_high, child_bad, aligned_bucket, input ready);
   modport sink(input valid, range_low, range_high, slot_for_bucket, bucket_absent,
                child_low, child_high, child_bad, aligned_bucket, output ready);
endinterface

// File: sv/radix_page_bucket_range_index.sv
// ----------------------------------------------------------------------------
// radix_page_bucket_range_index
// Page range, child slot, delegated child range and aligned bucket unit.
// ----------------------------------------------------------------------------
// Usage:
//   req_chan carries one page query (level, first bucket, query bucket,
//   query child); rsp_chan returns one result per query. Both channels
//   transfer on a clock edge with valid and ready high.
//   csr_wr_en / csr_wr_data write the fanout register (reset 512); a value
//   of 0 or 1 acts as 2. Write it only while the block is idle.
// Throughput:
//   One query at a time. The power loop runs on one 64x16 multiplier, one
//   step per cycle, and stops early once fanout^level leaves 64 bits;
//   then two 64-step restoring divisions share one divider (slot, then
//   alignment), each one quotient bit per cycle.
// Reset:
//   Synchronous, active high: controller back to idle, response slot empty,
//   fanout back to 512.
// Stall:
//   The result sits in an output register; while the receiver stalls, the
//   next query is accepted and computed and waits to publish until the
//   output register frees up.
// ----------------------------------------------------------------------------
module radix_page_bucket_range_index (
   input  logic         clock,
   input  logic         reset,
   input  logic         csr_wr_en,
   input  logic [15:0]  csr_wr_data,
   rpbri_req_if.sink    req_chan,
   rpbri_rsp_if.source  rsp_chan
);

   rpbri_pkg::cmd_type    cmd;
   rpbri_pkg::status_type status;
   rpbri_pkg::req_type    req_data;
   rpbri_pkg::rsp_type    rsp_data;
   logic                  rsp_valid;

   // pack the request payload for the datapath
   assign req_data.page_level        = req_chan.page_level;
   assign req_data.page_first_bucket = req_chan.page_first_bucket;
   assign req_data.query_bucket      = req_chan.query_bucket;
   assign req_data.query_child       = req_chan.query_child;

   rpbri_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_chan.ready),
      .status    (status),
      .cmd       (cmd)
   );

   rpbri_dp u_dp (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .req_data    (req_data),
      .cmd         (cmd),
      .status      (status),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_chan.ready),
      .rsp_data    (rsp_data)
   );

   // drive the response channel from the output register
   assign rsp_chan.valid           = rsp_valid;
   assign rsp_chan.range_low       = rsp_data.range_low;
   assign rsp_chan.range_high      = rsp_data.range_high;
   assign rsp_chan.slot_for_bucket = rsp_data.slot_for_bucket;
   assign rsp_chan.bucket_absent   = rsp_data.bucket_absent;
   assign rsp_chan.child_low       = rsp_data.child_low;
   assign rsp_chan.child_high      = rsp_data.child_high;
   assign rsp_chan.child_bad       = rsp_data.child_bad;
   assign rsp_chan.aligned_bucket  = rsp_data.aligned_bucket;

endmodule

// File: sv/rpbri_ctrl.sv
// ----------------------------------------------------------------------------
// rpbri_ctrl
// Sequencer: steps the datapath through power, range, child, divisions and publish.
// ----------------------------------------------------------------------------
module rpbri_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  rpbri_pkg::status_type status,
   output rpbri_pkg::cmd_type    cmd
);

   typedef enum logic [3:0] {
      S_IDLE, S_POW, S_SPAN, S_RANGE, S_OFF, S_CLO, S_CHI,
      S_SINIT, S_SDIV, S_SSAVE, S_ADIV, S_ASAVE, S_PUB
   } state_type;

   state_type state_ff, state_in;

   always_comb begin
      state_in = state_ff;
      cmd.op   = rpbri_pkg::OP_NONE;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.op   = rpbri_pkg::OP_LOAD;
               state_in = S_POW;
            end
         end
         S_POW: begin
            cmd.op = rpbri_pkg::OP_POW;
            if (status.pow_done) state_in = S_SPAN;
         end
         S_SPAN:  begin cmd.op = rpbri_pkg::OP_SPAN;  state_in = S_RANGE; end
         S_RANGE: begin cmd.op = rpbri_pkg::OP_RANGE; state_in = S_OFF;   end
         S_OFF:   begin cmd.op = rpbri_pkg::OP_OFF;   state_in = S_CLO;   end
         S_CLO:   begin cmd.op = rpbri_pkg::OP_CLO;   state_in = S_CHI;   end
         S_CHI:   begin cmd.op = rpbri_pkg::OP_CHI;   state_in = S_SINIT; end
         S_SINIT: begin cmd.op = rpbri_pkg::OP_SDIV_INIT; state_in = S_SDIV; end
         S_SDIV: begin
            cmd.op = rpbri_pkg::OP_DIV;
            if (status.div_done) begin
               cmd.op   = rpbri_pkg::OP_SSAVE;
               state_in = S_ADIV;
            end
         end
         S_SSAVE: begin cmd.op = rpbri_pkg::OP_SSAVE; state_in = S_ADIV; end
         S_ADIV: begin
            // hold the remainder once the last quotient bit is in
            if (status.div_done) state_in = S_ASAVE;
            else                 cmd.op   = rpbri_pkg::OP_DIV;
         end
         S_ASAVE: begin cmd.op = rpbri_pkg::OP_ASAVE; state_in = S_PUB; end
         S_PUB: begin
            if (status.out_free) begin
               cmd.op   = rpbri_pkg::OP_PUB;
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   assign req_ready = (state_ff == S_IDLE);

   always_ff @(posedge clock) begin
      if (reset) state_ff <= S_IDLE;
      else       state_ff <= state_in;
   end

endmodule

// File: sv/rpbri_dp.sv
// ----------------------------------------------------------------------------
// rpbri_dp
// Datapath: shared 64x16 multiplier, restoring divider, output register.
// ----------------------------------------------------------------------------
module rpbri_dp (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_wr_en,
   input  logic [15:0]           csr_wr_data,
   input  rpbri_pkg::req_type    req_data,
   input  rpbri_pkg::cmd_type    cmd,
   output rpbri_pkg::status_type status,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output rpbri_pkg::rsp_type    rsp_data
);

   logic [15:0] fanout_ff;
   logic [15:0] f_ff;
   logic [7:0]  lvl_ff;
   logic        ovf_ff;
   logic [63:0] r_ff, first_ff, bucket_ff;
   logic [31:0] child_ff;
   logic [63:0] cspan_ff, pspan_ff, high_ff, off_ff, clow_ff, chigh_ff;
   logic        cok_ff, pok_ff, offok_ff, absent_ff, cbad_ff, need_chi_ff;
   logic [15:0] slot_ff;
   logic [63:0] aligned_ff;
   logic [63:0] rem_ff, quo_ff, dvs_ff;
   logic [6:0]  dcnt_ff;
   logic        rsp_valid_ff;
   rpbri_pkg::rsp_type out_ff;

   logic [63:0] mul_a;
   logic [15:0] mul_b;
   logic [79:0] prod;
   logic [64:0] sum_hi, sum_clo, sum_chi;
   logic [64:0] pr;
   logic        ge;
   logic        child_in;

   assign mul_a = (cmd.op == rpbri_pkg::OP_OFF) ? cspan_ff : r_ff;
   assign mul_b = (cmd.op == rpbri_pkg::OP_OFF) ? child_ff[15:0] : f_ff;
   assign prod  = {16'd0, mul_a} * {64'd0, mul_b};

   assign sum_hi  = {1'b0, first_ff} + {1'b0, pspan_ff - 64'd1};
   assign sum_clo = {1'b0, first_ff} + {1'b0, off_ff};
   assign sum_chi = {1'b0, clow_ff} + {1'b0, cspan_ff - 64'd1};
   assign child_in = (child_ff < {16'd0, f_ff});

   assign pr = {rem_ff, quo_ff[63]};
   assign ge = (pr >= {1'b0, dvs_ff});

   assign status.pow_done = (lvl_ff == 8'd0) || ovf_ff;
   assign status.div_done = (dcnt_ff == 7'd0);
   assign status.out_free = !rsp_valid_ff || rsp_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         fanout_ff    <= rpbri_pkg::FANOUT_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_wr_en) fanout_ff <= csr_wr_data;
         if (cmd.op == rpbri_pkg::OP_PUB) rsp_valid_ff <= 1'b1;
         else if (rsp_ready)              rsp_valid_ff <= 1'b0;
      end

      case (cmd.op)
         rpbri_pkg::OP_LOAD: begin
            f_ff      <= (fanout_ff < 16'd2) ? 16'd2 : fanout_ff;
            lvl_ff    <= req_data.page_level;
            ovf_ff    <= 1'b0;
            r_ff      <= 64'd1;
            first_ff  <= req_data.page_first_bucket;
            bucket_ff <= req_data.query_bucket;
            child_ff  <= req_data.query_child;
         end
         rpbri_pkg::OP_POW: begin
            if (!((lvl_ff == 8'd0) || ovf_ff)) begin
               if (prod[79:64] != 16'd0) ovf_ff <= 1'b1;
               else                      r_ff   <= prod[63:0];
               lvl_ff <= lvl_ff - 8'd1;
            end
         end
         rpbri_pkg::OP_SPAN: begin
            cspan_ff <= r_ff;
            cok_ff   <= !ovf_ff;
            pok_ff   <= !ovf_ff && (prod[79:64] == 16'd0);
            pspan_ff <= prod[63:0];
         end
         rpbri_pkg::OP_RANGE: begin
            high_ff <= (pok_ff && !sum_hi[64]) ? sum_hi[63:0] : rpbri_pkg::ALL_ONES;
         end
         rpbri_pkg::OP_OFF: begin
            off_ff    <= prod[63:0];
            offok_ff  <= (prod[79:64] == 16'd0);
            absent_ff <= (bucket_ff < first_ff) || (bucket_ff > high_ff);
         end
         rpbri_pkg::OP_CLO: begin
            clow_ff     <= rpbri_pkg::ALL_ONES;
            chigh_ff    <= 64'd0;
            cbad_ff     <= 1'b1;
            need_chi_ff <= 1'b0;
            if (child_in) begin
               if (!cok_ff) begin
                  if (child_ff == 32'd0) begin
                     clow_ff  <= first_ff;
                     chigh_ff <= rpbri_pkg::ALL_ONES;
                     cbad_ff  <= 1'b0;
                  end
               end else if (offok_ff && !sum_clo[64]) begin
                  clow_ff     <= sum_clo[63:0];
                  cbad_ff     <= 1'b0;
                  need_chi_ff <= 1'b1;
               end
            end
         end
         rpbri_pkg::OP_CHI: begin
            if (need_chi_ff)
               chigh_ff <= sum_chi[64] ? rpbri_pkg::ALL_ONES : sum_chi[63:0];
         end
         rpbri_pkg::OP_SDIV_INIT: begin
            rem_ff  <= 64'd0;
            quo_ff  <= bucket_ff - first_ff;
            dvs_ff  <= cspan_ff;
            dcnt_ff <= 7'(rpbri_pkg::DIV_STEPS);
         end
         rpbri_pkg::OP_DIV: begin
            rem_ff  <= ge ? 64'(pr - {1'b0, dvs_ff}) : pr[63:0];
            quo_ff  <= {quo_ff[62:0], ge};
            dcnt_ff <= dcnt_ff - 7'd1;
         end
         rpbri_pkg::OP_SSAVE: begin
            slot_ff <= (!absent_ff && cok_ff) ? quo_ff[15:0] : 16'd0;
            rem_ff  <= 64'd0;
            quo_ff  <= bucket_ff;
            dvs_ff  <= pspan_ff;
            dcnt_ff <= 7'(rpbri_pkg::DIV_STEPS);
         end
         rpbri_pkg::OP_ASAVE: begin
            aligned_ff <= pok_ff ? (bucket_ff - rem_ff) : 64'd0;
         end
         rpbri_pkg::OP_PUB: begin
            out_ff.range_low       <= first_ff;
            out_ff.range_high      <= high_ff;
            out_ff.slot_for_bucket <= slot_ff;
            out_ff.bucket_absent   <= absent_ff;
            out_ff.child_low       <= clow_ff;
            out_ff.child_high      <= chigh_ff;
            out_ff.child_bad       <= cbad_ff;
            out_ff.aligned_bucket  <= aligned_ff;
         end
         default: ;
      endcase
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = out_ff;

endmodule

// File: sv/rpbri_checker.sv
// ----------------------------------------------------------------------------
// rpbri_checker
// Port-level checks of the index unit, bound to the top level.
// ----------------------------------------------------------------------------
module rpbri_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [15:0] slot_for_bucket,
   input logic        bucket_absent,
   input logic [63:0] range_low,
   input logic [63:0] range_high,
   input logic [63:0] child_low,
   input logic [63:0] child_high,
   input logic        child_bad
);

   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("response dropped while stalled");

   a_absent_slot: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && bucket_absent |-> slot_for_bucket == 16'd0)
      else $error("absent bucket with nonzero slot");

   a_bad_child: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && child_bad |-> child_low == {64{1'b1}} && child_high == 64'd0)
      else $error("bad child with a range");

   a_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> range_low <= range_high)
      else $error("page range inverted");

endmodule

bind radix_page_bucket_range_index rpbri_checker u_checker (
   .clock           (clock),
   .reset           (reset),
   .rsp_valid       (rsp_chan.valid),
   .rsp_ready       (rsp_chan.ready),
   .slot_for_bucket (rsp_chan.slot_for_bucket),
   .bucket_absent   (rsp_chan.bucket_absent),
   .range_low       (rsp_chan.range_low),
   .range_high      (rsp_chan.range_high),
   .child_low       (rsp_chan.child_low),
   .child_high      (rsp_chan.child_high),
   .child_bad       (rsp_chan.child_bad)
);

// File: tb/sv/radix_page_bucket_range_index_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// radix_page_bucket_range_index_tb
// Drives page queries through the radix page index unit under several fanout
// settings, predicts each result and compares it field by field in order.
// ----------------------------------------------------------------------------

import rpbri_pkg::*;

class page_index_board;
   rsp_type pending_q[$];
   bit [15:0] fanout_reg;
   int errors;

   function new();
      fanout_reg = FANOUT_RESET;
      errors = 0;
   endfunction

   // fanout^e in 128-bit arithmetic; ok clears when it leaves 64 bits
   function automatic bit radix_pow(int unsigned e, output bit [63:0] res);
      bit [127:0] acc;
      bit [63:0] f;
      f = (fanout_reg < 2) ? 64'd2 : {48'd0, fanout_reg};
      acc = 1;
      res = 0;
      for (int unsigned i = 0; i < e; i++) begin
         acc = acc * f;
         if (acc[127:64] != 0) return 0;
      end
      res = acc[63:0];
      return 1;
   endfunction

   function void note_query(req_type q);
      rsp_type r;
      bit [63:0] pspan, cspan, f;
      bit [64:0] sum;
      bit [127:0] off;
      bit pok, cok;
      f = (fanout_reg < 2) ? 64'd2 : {48'd0, fanout_reg};
      pok = radix_pow(q.page_level + 1, pspan);
      cok = radix_pow(q.page_level, cspan);
      r.range_low = q.page_first_bucket;
      r.range_high = ALL_ONES;
      if (pok) begin
         sum = {1'b0, q.page_first_bucket} + {1'b0, pspan} - 65'd1;
         if (!sum[64]) r.range_high = sum[63:0];
      end
      r.bucket_absent = (q.query_bucket < r.range_low) || (q.query_bucket > r.range_high);
      r.slot_for_bucket = 0;
      if (!r.bucket_absent && cok) begin
         off = (q.query_bucket - r.range_low) / cspan;
         r.slot_for_bucket = off[15:0];
      end
      r.child_low = ALL_ONES;
      r.child_high = 0;
      r.child_bad = 1;
      if ({32'd0, q.query_child} < f) begin
         if (!cok) begin
            if (q.query_child == 0) begin
               r.child_low = q.page_first_bucket;
               r.child_high = ALL_ONES;
               r.child_bad = 0;
            end
         end else begin
            off = {96'd0, q.query_child} * {64'd0, cspan};
            sum = {1'b0, q.page_first_bucket} + {1'b0, off[63:0]};
            if (off[127:64] == 0 && !sum[64]) begin
               r.child_low = sum[63:0];
               r.child_bad = 0;
               sum = {1'b0, r.child_low} + {1'b0, cspan} - 65'd1;
               r.child_high = sum[64] ? ALL_ONES : sum[63:0];
            end
         end
      end
      r.aligned_bucket = pok ? (q.query_bucket / pspan) * pspan : 64'd0;
      pending_q.push_back(r);
   endfunction

   function void check_result(rsp_type a);
      rsp_type e;
      if (pending_q.size() == 0) begin
         $display("%0t: unexpected result, expected none, actual %h", $time, a);
         errors++;
         return;
      end
      e = pending_q.pop_front();
      if (e.range_low != a.range_low) begin
         $display("%0t: range_low expected %h actual %h", $time, e.range_low, a.range_low);
         errors++;
      end
      if (e.range_high != a.range_high) begin
         $display("%0t: range_high expected %h actual %h", $time, e.range_high, a.range_high);
         errors++;
      end
      if (e.slot_for_bucket != a.slot_for_bucket) begin
         $display("%0t: slot_for_bucket expected %h actual %h", $time,
                  e.slot_for_bucket, a.slot_for_bucket);
         errors++;
      end
      if (e.bucket_absent != a.bucket_absent) begin
         $display("%0t: bucket_absent expected %b actual %b", $time,
                  e.bucket_absent, a.bucket_absent);
         errors++;
      end
      if (e.child_low != a.child_low) begin
         $display("%0t: child_low expected %h actual %h", $time, e.child_low, a.child_low);
         errors++;
      end
      if (e.child_high != a.child_high) begin
         $display("%0t: child_high expected %h actual %h", $time, e.child_high, a.child_high);
         errors++;
      end
      if (e.child_bad != a.child_bad) begin
         $display("%0t: child_bad expected %b actual %b", $time, e.child_bad, a.child_bad);
         errors++;
      end
      if (e.aligned_bucket != a.aligned_bucket) begin
         $display("%0t: aligned_bucket expected %h actual %h", $time,
                  e.aligned_bucket, a.aligned_bucket);
         errors++;
      end
   endfunction
endclass

module radix_page_bucket_range_index_tb;
   logic clock = 0;
   logic reset = 1;
   logic csr_wr_en = 0;
   logic [15:0] csr_wr_data = 0;
   bit hold_off = 0;
   bit stim_done = 0;

   rpbri_req_if req_chan();
   rpbri_rsp_if rsp_chan();

   page_index_board board = new();

   radix_page_bucket_range_index uut (
      .clock(clock), .reset(reset), .csr_wr_en(csr_wr_en), .csr_wr_data(csr_wr_data),
      .req_chan(req_chan.sink), .rsp_chan(rsp_chan.source)
   );

   always #10 clock = ~clock;

   initial begin
      req_chan.valid = 0;
      req_chan.page_level = 0;
      req_chan.page_first_bucket = 0;
      req_chan.query_bucket = 0;
      req_chan.query_child = 0;
      rsp_chan.ready = 0;
   end

   // Receiver: stall on its own pattern; a long hold-off fills the block.
   always @(posedge clock) begin
      if (reset || hold_off) begin
         rsp_chan.ready <= 0;
      end else begin
         case ($urandom_range(0, 3))
            0: rsp_chan.ready <= ($urandom_range(0, 3) == 0);
            default: rsp_chan.ready <= 1;
         endcase
      end
   end

   // Sample results at the edge where the transfer happens.
   always @(posedge clock) begin
      if (!reset && rsp_chan.valid && rsp_chan.ready) begin
         rsp_type got;
         got.range_low = rsp_chan.range_low;
         got.range_high = rsp_chan.range_high;
         got.slot_for_bucket = rsp_chan.slot_for_bucket;
         got.bucket_absent = rsp_chan.bucket_absent;
         got.child_low = rsp_chan.child_low;
         got.child_high = rsp_chan.child_high;
         got.child_bad = rsp_chan.child_bad;
         got.aligned_bucket = rsp_chan.aligned_bucket;
         board.check_result(got);
      end
   end

   // Offer one query and hold it until the transfer; note it at acceptance.
   task automatic send_query(req_type q);
      req_chan.valid <= 1;
      req_chan.page_level <= q.page_level;
      req_chan.page_first_bucket <= q.page_first_bucket;
      req_chan.query_bucket <= q.query_bucket;
      req_chan.query_child <= q.query_child;
      do @(posedge clock); while (!req_chan.ready);
      board.note_query(q);
   endtask

   task automatic idle_sender(int n);
      req_chan.valid <= 0;
      repeat (n) @(posedge clock);
   endtask

   // Drain every expected result, then allow for one more query in flight.
   task automatic wait_drained();
      req_chan.valid <= 0;
      while (board.pending_q.size() != 0) @(posedge clock);
      repeat (250) @(posedge clock);
   endtask

   task automatic write_fanout(bit [15:0] v);
      csr_wr_en <= 1;
      csr_wr_data <= v;
      @(posedge clock);
      csr_wr_en <= 0;
      board.fanout_reg = v;
   endtask

   function automatic bit [63:0] rand64();
      return {$urandom(), $urandom()};
   endfunction

   // Random query shaped to land near the page range and legal child slots.
   function automatic req_type rand_query();
      req_type q;
      bit [63:0] span;
      bit ok;
      int f;
      f = (board.fanout_reg < 2) ? 2 : board.fanout_reg;
      q.page_level = ($urandom_range(0, 9) == 0) ? 8'($urandom()) : 8'($urandom_range(0, 8));
      q.page_first_bucket = rand64();
      ok = board.radix_pow(q.page_level + 1, span);
      if (ok && $urandom_range(0, 1)) q.page_first_bucket = (q.page_first_bucket / span) * span;
      case ($urandom_range(0, 3))
         0: q.query_bucket = rand64();
         1: q.query_bucket = q.page_first_bucket + (ok ? rand64() % span : rand64());
         2: q.query_bucket = q.page_first_bucket - 64'($urandom_range(0, 3));
         default: q.query_bucket = ok ? q.page_first_bucket + span - 64'($urandom_range(0, 2))
                                      : ALL_ONES - 64'($urandom_range(0, 3));
      endcase
      case ($urandom_range(0, 3))
         0: q.query_child = $urandom();
         1: q.query_child = f - $urandom_range(0, 1);
         default: q.query_child = $urandom_range(0, f - 1);
      endcase
      return q;
   endfunction

   task automatic random_phase(int n);
      int sent = 0;
      while (sent < n) begin
         int burst = $urandom_range(1, 12);
         for (int i = 0; i < burst && sent < n; i++) begin
            send_query(rand_query());
            sent++;
         end
         if ($urandom_range(0, 2) == 0) idle_sender($urandom_range(1, 300));
      end
   endtask

   initial begin
      req_type q;
      bit [15:0] fanouts[6] = '{16'd0, 16'd1, 16'd2, 16'd3, 16'd65535, 16'd16};
      repeat (12) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      // Directed: field extremes, overflow, child bounds, absent buckets.
      q = '{8'd0, 64'd0, 64'd0, 32'd0}; send_query(q);
      q = '{8'd255, ALL_ONES, ALL_ONES, 32'hFFFF_FFFF}; send_query(q);
      q = '{8'd7, 64'd0, ALL_ONES, 32'd0}; send_query(q);     // page span overflow, child 0
      q = '{8'd7, 64'd5, 64'd100, 32'd1}; send_query(q);     // nonzero child, span overflow
      q = '{8'd1, 64'd1000, 64'd10, 32'd511}; send_query(q); // bucket below range
      q = '{8'd1, ALL_ONES - 64'd10, ALL_ONES, 32'd511}; send_query(q); // range saturates
      q = '{8'd0, 64'd4096, 64'd4096 + 64'd511, 32'd512}; send_query(q);
      q = '{8'd6, 64'd0, 64'h0123_4567_89AB_CDEF, 32'd3}; send_query(q);
      q = '{8'd2, ALL_ONES - 64'h40000, 64'd7, 32'd200}; send_query(q);
      q = '{8'hAA, 64'hAAAA_AAAA_AAAA_AAAA, 64'h5555_5555_5555_5555, 32'h5555_5555};
      send_query(q);
      q = '{8'h55, 64'h5555_5555_5555_5555, 64'hAAAA_AAAA_AAAA_AAAA, 32'hAAAA_AAAA};
      send_query(q);

      // Pressure: hold the receiver off while the sender keeps offering.
      hold_off = 1;
      fork
         repeat (800) @(posedge clock);
         for (int i = 0; i < 6; i++) send_query(rand_query());
      join_any
      hold_off = 0;
      wait fork;
      wait_drained();

      random_phase(400);
      foreach (fanouts[k]) begin
         wait_drained();
         write_fanout(fanouts[k]);
         // Directed extremes under each fanout.
         send_query('{8'd63, 64'd0, ALL_ONES, 32'd0});
         send_query('{8'd0, ALL_ONES, ALL_ONES, 32'd1});
         random_phase(260);
      end
      wait_drained();
      stim_done = 1;
   end

   initial begin
      wait (stim_done);
      if (board.errors == 0 && board.pending_q.size() == 0) begin
         $display("radix_page_bucket_range_index_tb OK");
      end else begin
         $display("radix_page_bucket_range_index_tb NOT OK");
      end
      $finish;
   end

   // Watchdog: bounds a run of ~2000 items, with a wide margin.
   initial begin
      #200_000_000;
      $display("radix_page_bucket_range_index_tb NOT OK");
      $finish;
   end
endmodule

// File: radix_page_bucket_range_index.f
sv/rpbri_pkg.sv
sv/rpbri_ifs.sv
sv/rpbri_ctrl.sv
sv/rpbri_dp.sv
sv/radix_page_bucket_range_index.sv
sv/rpbri_checker.sv
tb/sv/radix_page_bucket_range_index_tb.sv
